@@ hw/rtl/ppp_pkg.sv @@
// Shared types, constants and the pixel placement function for the point projection block.
package ppp_pkg;

	localparam int COORD_W   = 32;
	localparam int DEPTH_W   = 32;
	localparam int SCREEN_W  = 16;
	localparam int ACC_W     = 64;
	localparam int CFG_W     = 64;
	localparam int CENTER_W  = 32;
	localparam int CFG_IDX_W = 3;
	// Quotient bits kept by the divider; one more bit flags a quotient past the clamp range.
	localparam int QUOT_W    = 17;
	localparam int SAT_LIMIT = 100000;

	localparam logic [CFG_IDX_W-1:0] REG_X_AB   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_X_CD   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_D_AB   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_D_CD   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_Y_AB   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_Y_CD   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER = 3'd6;

	localparam logic signed [SCREEN_W-1:0] SCREEN_MAX = 16'sh7FFF;
	localparam logic signed [SCREEN_W-1:0] SCREEN_MIN = 16'sh8000;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
	} point_t;

	typedef struct packed {
		logic signed [SCREEN_W-1:0] screen_x;
		logic signed [SCREEN_W-1:0] screen_y;
		logic signed [DEPTH_W-1:0]  depth;
		logic                       visible;
		logic signed [SCREEN_W-1:0] prev_screen_x;
		logic signed [SCREEN_W-1:0] prev_screen_y;
		logic                       prev_visible;
	} result_t;

	typedef struct packed {
		logic load;
		logic issue;
	} mac_ctl_t;

	typedef struct packed {
		logic [QUOT_W-1:0] quot;
		logic              rnz;
		logic              neg;
		logic              ovf;
	} div_res_t;

	// Floor quotient plus center, truncated toward zero as a whole and clamped to 16 bits.
	function automatic logic signed [SCREEN_W-1:0] place(input logic signed [SCREEN_W-1:0] c,
			input div_res_t r);
		logic [QUOT_W:0]          qmag;
		logic signed [QUOT_W+1:0] q;
		logic signed [QUOT_W+2:0] s;
		logic signed [SCREEN_W-1:0] res;
		qmag = {1'b0, r.quot} + (QUOT_W+1)'(r.neg & r.rnz);
		q = r.neg ? -$signed({1'b0, qmag}) : $signed({2'b00, r.quot});
		s = (QUOT_W+3)'(c) + (QUOT_W+3)'(q);
		if (s < 0 && r.rnz)
			s = s + (QUOT_W+3)'(1);
		if (r.ovf)
			res = r.neg ? SCREEN_MIN : SCREEN_MAX;
		else if (!r.neg && ({1'b0, r.quot} > (QUOT_W+1)'(SAT_LIMIT)))
			res = SCREEN_MAX;
		else if (r.neg && (qmag > (QUOT_W+1)'(SAT_LIMIT)))
			res = SCREEN_MIN;
		else if (s > (QUOT_W+3)'(SCREEN_MAX))
			res = SCREEN_MAX;
		else if (s < (QUOT_W+3)'(SCREEN_MIN))
			res = SCREEN_MIN;
		else
			res = s[SCREEN_W-1:0];
		return res;
	endfunction

endpackage

@@ hw/rtl/ppp_mac.sv @@
// Shared multiply-accumulate unit: one registered 32x32 product per cycle into a 64-bit sum.
module ppp_mac #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ppp_pkg::mac_ctl_t                    ctl,
	input  logic signed [ppp_pkg::COORD_W-1:0]   offset,
	input  logic signed [ppp_pkg::COORD_W-1:0]   coef,
	input  logic signed [ppp_pkg::COORD_W-1:0]   coord,
	output logic signed [ppp_pkg::ACC_W-1:0]     sum
);
	import ppp_pkg::*;

	logic signed [ACC_W-1:0] prod_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] term;
	logic                    pv_q;

	// Arithmetic shift gives the floor of the scaled product.
	assign term = prod_q >>> FRAC_BITS;
	assign sum  = acc_q + (pv_q ? term : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q <= 1'b0;
		end else if (ctl.load) begin
			pv_q <= 1'b0;
		end else begin
			pv_q <= ctl.issue;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load)
			acc_q <= ACC_W'(offset);
		else
			acc_q <= sum;
		if (ctl.issue)
			prod_q <= coef * coord;
	end

endmodule

@@ hw/rtl/ppp_div.sv @@
// Restoring divider, one quotient bit per cycle, with an overflow bit for large quotients.
module ppp_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [ppp_pkg::ACC_W-1:0]   num,
	input  logic [ppp_pkg::ACC_W-1:0]          den,
	output logic                               done,
	output ppp_pkg::div_res_t                  res
);
	import ppp_pkg::*;

	localparam int DVS_W = ACC_W + QUOT_W;
	localparam int STEPS = QUOT_W + 1;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [ACC_W-1:0]   rem_q;
	logic [DVS_W-1:0]   dvs_q;
	logic [QUOT_W:0]    quot_q;
	logic               neg_q;
	logic [ACC_W-1:0]   mag;
	logic [DVS_W:0]     diff;
	logic               take;

	assign mag  = num[ACC_W-1] ? (~num + ACC_W'(1)) : num;
	assign diff = {1'b0, DVS_W'(rem_q)} - {1'b0, dvs_q};
	assign take = !diff[DVS_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= mag;
			dvs_q  <= {den, {QUOT_W{1'b0}}};
			quot_q <= '0;
			neg_q  <= num[ACC_W-1];
		end else if (busy_q) begin
			if (take)
				rem_q <= diff[ACC_W-1:0];
			dvs_q  <= dvs_q >> 1;
			quot_q <= {quot_q[QUOT_W-1:0], take};
		end
	end

	assign done     = done_q;
	assign res.quot = quot_q[QUOT_W-1:0];
	assign res.ovf  = quot_q[QUOT_W];
	assign res.rnz  = |rem_q;
	assign res.neg  = neg_q;

endmodule

@@ hw/rtl/perspective_point_projection.sv @@
// Top level: configuration registers, row sequencer and result register of the point projection.
//
// channel   direction  handshake              payload
// in        sink       in_valid / in_ready    in_data (point_t)
// out       source     out_valid / out_ready  out_data (result_t)
// cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A point with positive depth takes three rows of three products on the shared multiplier,
// then two passes through the serial divider.
// A point with depth not positive finishes after the depth row.
// One point is in work at a time; in_ready is high only while the sequencer is idle.
// A finished word waits in the output register; the next point may be taken meanwhile and
// stalls in its last step until that word is taken. cfg_ready is always high.
// Reset clears the configuration, the held screen position and all control state.
module perspective_point_projection #(
	parameter int FRAC_BITS     = 16,
	parameter int VISIBLE_LIMIT = 8000
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  ppp_pkg::point_t                     in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output ppp_pkg::result_t                    out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ppp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ppp_pkg::CFG_W-1:0]           cfg_data
);
	import ppp_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MUL   = 3'd1;
	localparam logic [2:0] S_DRAIN = 3'd2;
	localparam logic [2:0] S_DIVX  = 3'd3;
	localparam logic [2:0] S_DIVY  = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	localparam logic [1:0] ROW_DEPTH = 2'd0;
	localparam logic [1:0] ROW_X     = 2'd1;
	localparam logic [1:0] ROW_Y     = 2'd2;

	localparam logic [1:0] TERM_LAST = 2'd2;

	localparam logic signed [SCREEN_W:0] VIS_LIM = (SCREEN_W+1)'(VISIBLE_LIMIT);

	logic [CFG_W-1:0]    x_ab_q, x_cd_q, d_ab_q, d_cd_q, y_ab_q, y_cd_q;
	logic [CENTER_W-1:0] center_q;

	logic [2:0] state_q;
	logic [1:0] row_q;
	logic [1:0] term_q;
	point_t     pt_q;

	logic signed [ACC_W-1:0]    depth_q, nx_q, ny_q;
	logic signed [SCREEN_W-1:0] sx_q, sy_q;
	logic                       dpos_q;
	logic signed [SCREEN_W-1:0] last_x_q, last_y_q;
	logic                       last_vis_q;
	result_t                    out_q;
	logic                       out_valid_q;

	logic [CFG_W-1:0]        cur_ab, cur_cd, ld_cd;
	logic [1:0]              ld_row;
	logic signed [COORD_W-1:0] coef, coord;
	mac_ctl_t                mac_ctl;
	logic signed [ACC_W-1:0] sum;
	logic                    sum_pos;

	logic                    div_start, div_done;
	logic signed [ACC_W-1:0] div_num;
	div_res_t                div_res;

	logic                    accept, fin_fire, vis;
	logic signed [SCREEN_W-1:0] cx, cy;
	logic signed [DEPTH_W-1:0]  depth_sat;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;
	assign fin_fire  = (state_q == S_FIN) && (!out_valid_q || out_ready);
	assign cx        = center_q[SCREEN_W-1:0];
	assign cy        = center_q[2*SCREEN_W-1:SCREEN_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_ab_q   <= '0;
			x_cd_q   <= '0;
			d_ab_q   <= '0;
			d_cd_q   <= '0;
			y_ab_q   <= '0;
			y_cd_q   <= '0;
			center_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_X_AB:   x_ab_q   <= cfg_data;
				REG_X_CD:   x_cd_q   <= cfg_data;
				REG_D_AB:   d_ab_q   <= cfg_data;
				REG_D_CD:   d_cd_q   <= cfg_data;
				REG_Y_AB:   y_ab_q   <= cfg_data;
				REG_Y_CD:   y_cd_q   <= cfg_data;
				REG_CENTER: center_q <= cfg_data[CENTER_W-1:0];
				default:    ;
			endcase
		end
	end

	// Coefficients of the row being multiplied.
	always_comb begin
		unique case (row_q)
			ROW_DEPTH: begin
				cur_ab = d_ab_q;
				cur_cd = d_cd_q;
			end
			ROW_X: begin
				cur_ab = x_ab_q;
				cur_cd = x_cd_q;
			end
			ROW_Y: begin
				cur_ab = y_ab_q;
				cur_cd = y_cd_q;
			end
			default: begin
				cur_ab = d_ab_q;
				cur_cd = d_cd_q;
			end
		endcase
		case (term_q)
			2'd0: begin
				coef  = cur_ab[COORD_W-1:0];
				coord = pt_q.point_x;
			end
			2'd1: begin
				coef  = cur_ab[CFG_W-1:COORD_W];
				coord = pt_q.point_y;
			end
			default: begin
				coef  = cur_cd[COORD_W-1:0];
				coord = pt_q.point_z;
			end
		endcase
	end

	// The accumulator is preloaded with the offset of the row that comes next.
	always_comb begin
		ld_row = (state_q == S_IDLE) ? ROW_DEPTH : row_q + 2'd1;
		unique case (ld_row)
			ROW_DEPTH: ld_cd = d_cd_q;
			ROW_X:     ld_cd = x_cd_q;
			ROW_Y:     ld_cd = y_cd_q;
			default:   ld_cd = d_cd_q;
		endcase
	end

	assign mac_ctl.load  = accept || (state_q == S_DRAIN);
	assign mac_ctl.issue = (state_q == S_MUL);

	ppp_mac #(
		.FRAC_BITS(FRAC_BITS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.offset (ld_cd[CFG_W-1:COORD_W]),
		.coef   (coef),
		.coord  (coord),
		.sum    (sum)
	);

	assign sum_pos = !sum[ACC_W-1] && (|sum);

	assign div_start = ((state_q == S_DRAIN) && (row_q == ROW_Y)) ||
		((state_q == S_DIVX) && div_done);
	assign div_num = (state_q == S_DIVX) ? -ny_q : nx_q;

	ppp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (depth_q),
		.done   (div_done),
		.res    (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			row_q   <= ROW_DEPTH;
			term_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						row_q   <= ROW_DEPTH;
						term_q  <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					term_q <= term_q + 2'd1;
					if (term_q == TERM_LAST)
						state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					term_q <= '0;
					if (row_q == ROW_Y) begin
						state_q <= S_DIVX;
					end else if (row_q == ROW_DEPTH && !sum_pos) begin
						state_q <= S_FIN;
					end else begin
						row_q   <= row_q + 2'd1;
						state_q <= S_MUL;
					end
				end
				S_DIVX: begin
					if (div_done)
						state_q <= S_DIVY;
				end
				S_DIVY: begin
					if (div_done)
						state_q <= S_FIN;
				end
				S_FIN: begin
					if (fin_fire)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			pt_q <= in_data;
		if (state_q == S_DRAIN) begin
			case (row_q)
				ROW_DEPTH: begin
					depth_q <= sum;
					dpos_q  <= sum_pos;
					if (!sum_pos) begin
						sx_q <= last_x_q;
						sy_q <= last_y_q;
					end
				end
				ROW_X:   nx_q <= sum;
				default: ny_q <= sum;
			endcase
		end
		if (state_q == S_DIVX && div_done)
			sx_q <= place(cx, div_res);
		if (state_q == S_DIVY && div_done)
			sy_q <= place(cy, div_res);
	end

	assign vis = dpos_q &&
		((SCREEN_W+1)'(sx_q) > -VIS_LIM) && ((SCREEN_W+1)'(sx_q) < VIS_LIM) &&
		((SCREEN_W+1)'(sy_q) > -VIS_LIM) && ((SCREEN_W+1)'(sy_q) < VIS_LIM);

	// Depth fits 32 bits when its upper bits are all copies of the sign.
	always_comb begin
		if ((&depth_q[ACC_W-1:DEPTH_W-1]) || !(|depth_q[ACC_W-1:DEPTH_W-1]))
			depth_sat = depth_q[DEPTH_W-1:0];
		else if (depth_q[ACC_W-1])
			depth_sat = {1'b1, {(DEPTH_W-1){1'b0}}};
		else
			depth_sat = {1'b0, {(DEPTH_W-1){1'b1}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			last_x_q    <= '0;
			last_y_q    <= '0;
			last_vis_q  <= 1'b0;
		end else begin
			if (fin_fire) begin
				out_valid_q <= 1'b1;
				last_x_q    <= sx_q;
				last_y_q    <= sy_q;
				last_vis_q  <= vis;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin_fire) begin
			out_q.screen_x      <= sx_q;
			out_q.screen_y      <= sy_q;
			out_q.depth         <= depth_sat;
			out_q.visible       <= vis;
			out_q.prev_screen_x <= last_x_q;
			out_q.prev_screen_y <= last_y_q;
			out_q.prev_visible  <= last_vis_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ hw/rtl/ppp_checker.sv @@
// Port-level checks of the point projection block and the bind that attaches them.
module ppp_checker #(
	parameter int VISIBLE_LIMIT = 8000
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input ppp_pkg::result_t               out_data
);
	import ppp_pkg::*;

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// The block works on one point at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again right after an accept");

	a_visible_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.visible |->
			out_data.depth > 0 &&
			out_data.screen_x > -VISIBLE_LIMIT && out_data.screen_x < VISIBLE_LIMIT &&
			out_data.screen_y > -VISIBLE_LIMIT && out_data.screen_y < VISIBLE_LIMIT)
		else $error("visible point outside the limits or behind the eye");

	// Behind the eye the position repeats the previous one.
	a_hold_behind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.depth <= 0 |->
			!out_data.visible &&
			out_data.screen_x == out_data.prev_screen_x &&
			out_data.screen_y == out_data.prev_screen_y)
		else $error("screen position not held for a point behind the eye");

endmodule

bind perspective_point_projection ppp_checker #(
	.VISIBLE_LIMIT(VISIBLE_LIMIT)
) u_ppp_checker (.*);
